// ===== design/hamming_29_24_codec_defines.svh =====
// assertion macros for the hamming(29,24) codec
// used by files that assert; expects clk_i and rst_ni in scope
`ifndef HAMMING_29_24_CODEC_DEFINES_SVH
`define HAMMING_29_24_CODEC_DEFINES_SVH

// same-cycle implication, off during reset
`define HAM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define HAM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ham_pkg.sv =====
// types, constants and parity functions for the hamming(29,24) codec
// no dependencies
package ham_pkg;

  localparam int unsigned CodeW = 29;
  localparam int unsigned DataW = 24;
  localparam int unsigned SynW  = 5;

  localparam logic [SynW-1:0] CODE_BITS = 5'd29;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [7:0]        byte_first;
    logic [7:0]        byte_second;
    logic [7:0]        byte_third;
    logic [CodeW-1:0]  code_in;
  } in_t;

  typedef struct packed {
    logic [CodeW-1:0]  code_out;
    logic [DataW-1:0]  data_out;
    logic [SynW-1:0]   syndrome;
    logic              corrected;
    logic              uncorrectable;
  } out_t;

  // word bit of each data bit, data bit 0 first
  localparam logic [SynW-1:0] DATA_POS [DataW] = '{
    5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,
    5'd8,  5'd9,  5'd10, 5'd11, 5'd12, 5'd14, 5'd15, 5'd16,
    5'd17, 5'd18, 5'd19, 5'd20, 5'd22, 5'd23, 5'd24, 5'd26
  };

  // word bit of parity bit k (position 2^k)
  localparam logic [SynW-1:0] PAR_POS [SynW] = '{
    5'd28, 5'd27, 5'd25, 5'd21, 5'd13
  };

  // xor of the positions of all set bits; position p sits at bit 29-p
  function automatic logic [SynW-1:0] syndrome_of(logic [CodeW-1:0] w);
    logic [SynW-1:0] s;
    s = '0;
    for (int p = 1; p <= CodeW; p++) begin
      if (w[CodeW-p]) begin
        s = s ^ SynW'(p);
      end
    end
    return s;
  endfunction

  function automatic logic [DataW-1:0] extract_data(logic [CodeW-1:0] w);
    logic [DataW-1:0] d;
    d = '0;
    for (int i = 0; i < DataW; i++) begin
      d[i] = w[DATA_POS[i]];
    end
    return d;
  endfunction

  function automatic logic [CodeW-1:0] encode_data(logic [DataW-1:0] d);
    logic [CodeW-1:0] w;
    logic [SynW-1:0]  s;
    w = '0;
    for (int i = 0; i < DataW; i++) begin
      w[DATA_POS[i]] = d[i];
    end
    s = syndrome_of(w);
    for (int k = 0; k < SynW; k++) begin
      w[PAR_POS[k]] = s[k];
    end
    return w;
  endfunction

endpackage

// ===== design/hamming_29_24_codec.sv =====
// hamming(29,24) codec top level: input register, datapath, result register
// depends on ham_pkg, ham_core and hamming_29_24_codec_defines.svh
// a start transfer passes the input register and the result register before the done_o strobe
// throughput: one command per cycle; busy_o is never raised
// done_o marks each result for one cycle only and res_o holds it until the next one, the receiver cannot stall
// reset clears the valid flags only; no other state
`include "hamming_29_24_codec_defines.svh"

module hamming_29_24_codec (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ham_pkg::in_t  cmd_i,
  output logic          busy_o,
  output logic          done_o,
  output ham_pkg::out_t res_o
);
  import ham_pkg::*;

  logic in_valid_q;
  logic res_valid_q;
  in_t  cmd_q;
  out_t res_d;
  out_t res_q;
  logic accept;
  logic syn_in_range;
  logic syn_beyond;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= accept;
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  ham_core u_core (
    .cmd_i (cmd_q),
    .res_o (res_d)
  );

  assign done_o = res_valid_q;
  assign res_o  = res_q;

  assign syn_in_range = (res_o.syndrome != '0) && (res_o.syndrome <= CODE_BITS);
  assign syn_beyond   = (res_o.syndrome > CODE_BITS);

  `HAM_ASSERT_NXT(a_done_follows, accept, ##1 done_o, "no result two cycles after a transfer")
  `HAM_ASSERT_IMP(a_flags_excl, done_o, !(res_o.corrected && res_o.uncorrectable), "flags clash")
  `HAM_ASSERT_IMP(a_fix_syn, done_o && res_o.corrected, syn_in_range, "correction out of range")
  `HAM_ASSERT_IMP(a_bad_syn, done_o && res_o.uncorrectable, syn_beyond, "uncorrectable in range")

endmodule

// ===== design/ham_core.sv =====
// encode / check-and-correct datapath of the hamming(29,24) codec
// combinational xor trees; uses ham_pkg
module ham_core (
  input  ham_pkg::in_t  cmd_i,
  output ham_pkg::out_t res_o
);
  import ham_pkg::*;

  logic [CodeW-1:0] enc_word;
  logic [SynW-1:0]  dec_syn;
  logic             dec_fix;
  logic             dec_bad;
  logic [SynW-1:0]  flip_idx;
  logic [CodeW-1:0] dec_word;
  logic [CodeW-1:0] word;

  assign enc_word = encode_data({cmd_i.byte_first, cmd_i.byte_second, cmd_i.byte_third});

  assign dec_syn  = syndrome_of(cmd_i.code_in);
  assign dec_fix  = (dec_syn != '0) && (dec_syn <= CODE_BITS);
  assign dec_bad  = (dec_syn > CODE_BITS);
  // only meaningful when dec_fix is set
  assign flip_idx = CODE_BITS - dec_syn;
  assign dec_word = cmd_i.code_in ^ (dec_fix ? (CodeW'(1) << flip_idx) : '0);

  always_comb begin
    unique case (cmd_i.op)
      OP_ENCODE: begin
        word                = enc_word;
        res_o.syndrome      = '0;
        res_o.corrected     = 1'b0;
        res_o.uncorrectable = 1'b0;
      end
      OP_DECODE: begin
        word                = dec_word;
        res_o.syndrome      = dec_syn;
        res_o.corrected     = dec_fix;
        res_o.uncorrectable = dec_bad;
      end
      default: begin
        word                = '0;
        res_o.syndrome      = '0;
        res_o.corrected     = 1'b0;
        res_o.uncorrectable = 1'b0;
      end
    endcase
    res_o.code_out = word;
    res_o.data_out = extract_data(word);
  end

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the hamming(29,24) codec: directed and random commands
// depends on ham_pkg and the hamming_29_24_codec top level
module testbench;
  import ham_pkg::*;

  localparam int unsigned ResultLatency = 2;
  localparam int unsigned PhaseItems    = 430;
  localparam int unsigned IdleMix [3]   = '{8, 57, 0};

  logic  clk_i   = 1'b0;
  logic  rst_ni  = 1'b0;
  logic  start_i = 1'b0;
  in_t   cmd_i   = '0;
  logic  busy_o;
  logic  done_o;
  out_t  res_o;

  in_t   codec_cmds [$];
  out_t  expected_words [$];
  out_t  oldest_word;
  int    sender_idle_pct = 0;
  int    mismatch_count  = 0;

  hamming_29_24_codec dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #2 clk_i = ~clk_i;

  // check bit k is the xor of every word bit whose position has bit k set
  function automatic logic [SynW-1:0] check_bits(logic [CodeW-1:0] w);
    logic [SynW-1:0] s;
    int pos;
    s = '0;
    for (int b = 0; b < CodeW; b++) begin
      pos = CodeW - b;
      for (int k = 0; k < SynW; k++) begin
        if (pos[k]) begin
          s[k] = s[k] ^ w[b];
        end
      end
    end
    return s;
  endfunction

  // data fills the non power-of-two positions, msb at the lowest position
  function automatic logic [DataW-1:0] pull_data(logic [CodeW-1:0] w);
    logic [DataW-1:0] d;
    int d_idx;
    d = '0;
    d_idx = DataW - 1;
    for (int pos = 1; pos <= CodeW; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        d[d_idx] = w[CodeW-pos];
        d_idx--;
      end
    end
    return d;
  endfunction

  function automatic logic [CodeW-1:0] build_codeword(logic [DataW-1:0] d);
    logic [CodeW-1:0] w;
    logic [SynW-1:0]  s;
    int d_idx;
    w = '0;
    d_idx = DataW - 1;
    for (int pos = 1; pos <= CodeW; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        w[CodeW-pos] = d[d_idx];
        d_idx--;
      end
    end
    s = check_bits(w);
    for (int k = 0; k < SynW; k++) begin
      w[CodeW-(1<<k)] = s[k];
    end
    return w;
  endfunction

  function automatic out_t predict_codec(in_t c);
    out_t r;
    logic [CodeW-1:0] w;
    logic [SynW-1:0]  s;
    r = '0;
    if (c.op == OP_ENCODE) begin
      w = build_codeword({c.byte_first, c.byte_second, c.byte_third});
    end else begin
      w = c.code_in;
      s = check_bits(w);
      r.syndrome = s;
      if (s >= 1 && s <= CODE_BITS) begin
        w[CodeW-int'(s)] = ~w[CodeW-int'(s)];
        r.corrected = 1'b1;
      end else if (s > CODE_BITS) begin
        r.uncorrectable = 1'b1;
      end
    end
    r.code_out = w;
    r.data_out = pull_data(w);
    return r;
  endfunction

  function automatic logic [CodeW-1:0] flip_pos(logic [CodeW-1:0] w, int pos);
    w[CodeW-pos] = ~w[CodeW-pos];
    return w;
  endfunction

  // unused fields carry random filler so the block has to ignore them
  function automatic in_t encode_cmd(logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
    in_t c;
    c.op          = OP_ENCODE;
    c.byte_first  = b1;
    c.byte_second = b2;
    c.byte_third  = b3;
    c.code_in     = CodeW'($urandom);
    return c;
  endfunction

  function automatic in_t decode_cmd(logic [CodeW-1:0] w);
    in_t c;
    c.op          = OP_DECODE;
    c.byte_first  = 8'($urandom);
    c.byte_second = 8'($urandom);
    c.byte_third  = 8'($urandom);
    c.code_in     = w;
    return c;
  endfunction

  // encode commands, valid codewords with zero, one or two flips, and raw noise
  function automatic in_t random_cmd();
    logic [CodeW-1:0] w;
    int kind;
    int p;
    int q;
    kind = $urandom_range(99);
    if (kind < 35) begin
      return encode_cmd(8'($urandom), 8'($urandom), 8'($urandom));
    end
    if (kind >= 85) begin
      return decode_cmd(CodeW'($urandom));
    end
    w = build_codeword(DataW'($urandom));
    p = $urandom_range(CodeW, 1);
    if (kind >= 50) begin
      w = flip_pos(w, p);
    end
    if (kind >= 75) begin
      q = $urandom_range(CodeW - 1, 1);
      if (q >= p) begin
        q++;
      end
      w = flip_pos(w, q);
    end
    return decode_cmd(w);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // driver: predict on each accepted transfer, then offer the next command
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_words.push_back(predict_codec(cmd_i));
        void'(codec_cmds.pop_front());
      end
      if (codec_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        start_i <= 1'b1;
        cmd_i   <= codec_cmds[0];
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: every strobed result is matched against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($isunknown(done_o)) begin
        $error("done_o is unknown");
        mismatch_count++;
      end else if (done_o) begin
        if (expected_words.size() == 0) begin
          $error("result strobe with no command outstanding");
          mismatch_count++;
        end else begin
          oldest_word = expected_words.pop_front();
          check_field("code_out", 32'(oldest_word.code_out), 32'(res_o.code_out));
          check_field("data_out", 32'(oldest_word.data_out), 32'(res_o.data_out));
          check_field("syndrome", 32'(oldest_word.syndrome), 32'(res_o.syndrome));
          check_field("corrected", 32'(oldest_word.corrected), 32'(res_o.corrected));
          check_field("uncorrectable", 32'(oldest_word.uncorrectable),
                      32'(res_o.uncorrectable));
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    sender_idle_pct = IdleMix[0];
    codec_cmds.push_back(encode_cmd(8'h00, 8'h00, 8'h00));
    codec_cmds.push_back(encode_cmd(8'hFF, 8'hFF, 8'hFF));
    codec_cmds.push_back(encode_cmd(8'h80, 8'h00, 8'h01));
    codec_cmds.push_back(encode_cmd(8'hA5, 8'h5A, 8'hC3));
    codec_cmds.push_back(decode_cmd('0));
    codec_cmds.push_back(decode_cmd('1));
    codec_cmds.push_back(decode_cmd(build_codeword(24'hFFFFFF)));
    codec_cmds.push_back(decode_cmd(build_codeword(24'h123456)));
    // single flips on parity bits, the last position and data bits
    codec_cmds.push_back(decode_cmd(flip_pos(build_codeword(24'h123456), 1)));
    codec_cmds.push_back(decode_cmd(flip_pos(build_codeword(24'h123456), 16)));
    codec_cmds.push_back(decode_cmd(flip_pos(build_codeword(24'h123456), 3)));
    codec_cmds.push_back(decode_cmd(flip_pos(build_codeword(24'hABCDEF), 29)));
    // two flips whose positions xor to 30 and to 31: beyond the word
    codec_cmds.push_back(decode_cmd(flip_pos(flip_pos(build_codeword(24'h000000), 14), 16)));
    codec_cmds.push_back(decode_cmd(flip_pos(flip_pos(build_codeword(24'h00FF00), 15), 16)));
    // two flips that alias to a third, wrongly corrected position
    codec_cmds.push_back(decode_cmd(flip_pos(flip_pos(build_codeword(24'h5A5A5A), 5), 9)));

    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = IdleMix[ph];
      repeat (PhaseItems) codec_cmds.push_back(random_cmd());
      while (codec_cmds.size() != 0) @(posedge clk_i);
    end

    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (ResultLatency + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== hamming_29_24_codec.f =====
+incdir+design
design/ham_pkg.sv
design/ham_core.sv
design/hamming_29_24_codec.sv
tb/testbench.sv
